/* rtl/cfa_pkg.sv */
// Package for the complementary filter attitude unit.
// Holds control state types, fixed widths, the CORDIC angle table and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package cfa_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MAG_OFFSET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_OFFSET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_OFFSET_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_SCALE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_SCALE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAG_SCALE_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_GAIN = 3'd6;

    localparam logic [15:0] SCALE_RESET = 16'd16384;
    localparam logic [15:0] GAIN_RESET = 16'd64225;

    localparam int BIAS_W = 24;
    localparam int COUNT_W = 9;
    localparam int DELTA_W = 26;
    localparam int MAG_W = 25;
    localparam int KPROD_W = 57;
    localparam int MACC_W = 89;
    localparam int QSHIFT = 40;
    localparam int DIV_W = 50;
    localparam int DIV_STEPS = 25;
    localparam int STEP_W = 33;
    localparam int CW = 36;
    localparam int ZW = 24;
    localparam int ANG_W = 15;

    localparam logic [31:0] STEP_K = 32'd3937335981;
    localparam logic signed [ZW-1:0] Z_QUARTER = 24'sd1474560;
    localparam logic signed [15:0] ANG_LIMIT = 16'sd11520;

    localparam logic [19:0] ATAN_TAB [16] = '{
        20'd737280, 20'd435242, 20'd229970, 20'd116736,
        20'd58595, 20'd29326, 20'd14667, 20'd7334,
        20'd3667, 20'd1833, 20'd917, 20'd458,
        20'd229, 20'd115, 20'd57, 20'd29
    };

    typedef enum logic [1:0] {
        PH_CALIB,
        PH_PRIME,
        PH_RUN
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_START,
        ST_LANES,
        ST_MERGE,
        ST_PUSH
    } t_ctl_st;

    typedef enum logic [1:0] {
        L_IDLE,
        L_MULK,
        L_MULT,
        L_DIV
    } t_lane_st;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ITER,
        C_FIN
    } t_cor_st;

    typedef enum logic [1:0] {
        M_IDLE,
        M_LO,
        M_HI,
        M_FIN
    } t_mrg_st;

    typedef struct packed {
        logic signed [15:0] state;
        logic signed [STEP_W-1:0] step;
        logic signed [ANG_W-1:0] acc;
    } t_blend_in;

endpackage

/* rtl/cfa_step_lane.sv */
// Gyro angle step lane: |D|*K by one multiply, times dt bit-serially, then radix-4 divide by N.
// Depends on cfa_pkg.
`timescale 1ns / 1ps

module cfa_step_lane #(
    parameter int CALIB_SAMPLES = 250
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [cfa_pkg::DELTA_W-1:0]   i_delta,
    input  logic [31:0]                          i_dt,
    output logic                                 o_busy,
    output logic signed [cfa_pkg::STEP_W-1:0]    o_step
);
    import cfa_pkg::*;

    localparam logic [9:0] DIVISOR = 10'(CALIB_SAMPLES);

    t_lane_st r_st, n_st;
    logic r_neg;
    logic [MAG_W-1:0] r_mag;
    logic [31:0] r_dt;
    logic [KPROD_W-1:0] r_a;
    logic [MACC_W-1:0] r_acc;
    logic [DIV_W-1:0] r_q;
    logic [8:0] r_rem;
    logic [4:0] r_cnt;
    logic signed [STEP_W-1:0] r_step;

    logic [MACC_W-1:0] acc_nx;
    logic [9:0] t1, t2, s1, s2;
    logic b1, b2;
    logic [DIV_W-1:0] q_nx;
    logic [30:0] p_sat;

    always_comb begin
        acc_nx = {r_acc[MACC_W-2:0], 1'b0} + (r_dt[31] ? MACC_W'(r_a) : '0);
        t1 = {r_rem, r_q[DIV_W-1]};
        b1 = (t1 >= DIVISOR);
        s1 = b1 ? (t1 - DIVISOR) : t1;
        t2 = {s1[8:0], r_q[DIV_W-2]};
        b2 = (t2 >= DIVISOR);
        s2 = b2 ? (t2 - DIVISOR) : t2;
        q_nx = {r_q[DIV_W-3:0], b1, b2};
        p_sat = (q_nx[DIV_W-1:31] != '0) ? 31'h7FFFFFFF : q_nx[30:0];
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            L_IDLE: if (i_start) n_st = L_MULK;
            L_MULK: n_st = L_MULT;
            L_MULT: if (r_cnt == 5'd31) n_st = L_DIV;
            L_DIV:  if (r_cnt == 5'(DIV_STEPS - 1)) n_st = L_IDLE;
            default: n_st = L_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_st != L_IDLE);
        o_step = r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= L_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            L_IDLE: begin
                if (i_start) begin
                    r_neg <= i_delta[DELTA_W-1];
                    r_mag <= MAG_W'(i_delta[DELTA_W-1] ? -i_delta : i_delta);
                    r_dt <= i_dt;
                end
            end
            L_MULK: begin
                r_a <= r_mag * STEP_K;
                r_acc <= '0;
                r_cnt <= '0;
            end
            L_MULT: begin
                r_acc <= acc_nx;
                r_dt <= {r_dt[30:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_q <= DIV_W'(acc_nx[MACC_W-1:QSHIFT]);
                    r_rem <= '0;
                    r_cnt <= '0;
                end
            end
            L_DIV: begin
                r_q <= q_nx;
                r_rem <= s2[8:0];
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    r_step <= r_neg ? -$signed({2'b00, p_sat}) : $signed({2'b00, p_sat});
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/cfa_cordic_lane.sv */
// atan2 lane: vectoring CORDIC, one micro-rotation per cycle, 1/64 degree result.
// Depends on cfa_pkg.
`timescale 1ns / 1ps

module cfa_cordic_lane (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [cfa_pkg::CW-1:0]      i_x,
    input  logic signed [cfa_pkg::CW-1:0]      i_y,
    output logic                               o_busy,
    output logic signed [cfa_pkg::ANG_W-1:0]   o_angle
);
    import cfa_pkg::*;

    t_cor_st r_st, n_st;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [3:0] r_i;
    logic r_zero;
    logic signed [ANG_W-1:0] r_angle;

    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] tab;
    logic signed [15:0] rnd;
    logic signed [ZW-1:0] zr;

    always_comb begin
        dx = r_x >>> r_i;
        dy = r_y >>> r_i;
        tab = $signed(ZW'(ATAN_TAB[r_i]));
        zr = (r_z + 24'sd128) >>> 8;
        rnd = zr[15:0];
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            C_IDLE: if (i_start) n_st = C_ITER;
            C_ITER: if (r_i == 4'd15) n_st = C_FIN;
            C_FIN:  n_st = C_IDLE;
            default: n_st = C_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_st != C_IDLE);
        o_angle = r_angle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= C_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            C_IDLE: begin
                if (i_start) begin
                    r_zero <= (i_x == '0) && (i_y == '0);
                    r_i <= '0;
                    if (i_x < 0) begin
                        if (i_y >= 0) begin
                            r_x <= i_y;
                            r_y <= -i_x;
                            r_z <= Z_QUARTER;
                        end else begin
                            r_x <= -i_y;
                            r_y <= i_x;
                            r_z <= -Z_QUARTER;
                        end
                    end else begin
                        r_x <= i_x;
                        r_y <= i_y;
                        r_z <= '0;
                    end
                end
            end
            C_ITER: begin
                r_i <= r_i + 4'd1;
                if (r_y > 0) begin
                    r_x <= r_x + dy;
                    r_y <= r_y - dx;
                    r_z <= r_z + tab;
                end else begin
                    r_x <= r_x - dy;
                    r_y <= r_y + dx;
                    r_z <= r_z - tab;
                end
            end
            C_FIN: begin
                if (r_zero) begin
                    r_angle <= '0;
                end else if (zr > ZW'(ANG_LIMIT)) begin
                    r_angle <= ANG_W'(ANG_LIMIT);
                end else if (zr < -ZW'(ANG_LIMIT)) begin
                    r_angle <= ANG_W'(-ANG_LIMIT);
                end else begin
                    r_angle <= ANG_W'(rnd);
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/cfa_merge.sv */
// Merge stage: blends gyro-propagated roll and pitch with accelerometer angles.
// Depends on cfa_pkg; one 16x17 multiply per cycle, roll then pitch.
`timescale 1ns / 1ps

module cfa_merge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [15:0]                 i_gain,
    input  cfa_pkg::t_blend_in          i_roll_in,
    input  cfa_pkg::t_blend_in          i_pitch_in,
    output logic                        o_busy,
    output logic signed [15:0]          o_roll,
    output logic signed [15:0]          o_pitch
);
    import cfa_pkg::*;

    t_mrg_st r_st, n_st;
    logic r_axis;
    logic signed [53:0] r_s;
    logic signed [15:0] r_roll, r_pitch;

    t_blend_in sel;
    logic signed [33:0] diff;
    logic [16:0] lo;
    logic signed [16:0] hi;
    logic [32:0] plo;
    logic signed [33:0] phi;
    logic signed [37:0] q;
    logic signed [15:0] qs;

    always_comb begin
        sel = r_axis ? i_pitch_in : i_roll_in;
        diff = 34'(sel.state) + 34'(sel.step) - 34'(sel.acc);
        lo = diff[16:0];
        hi = diff[33:17];
        plo = i_gain * lo;
        phi = $signed({1'b0, i_gain}) * hi;
        q = r_s[53:16];
        if (q > 38'sd32767) begin
            qs = 16'sh7FFF;
        end else if (q < -38'sd32768) begin
            qs = -16'sh8000;
        end else begin
            qs = q[15:0];
        end
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            M_IDLE: if (i_start) n_st = M_LO;
            M_LO:   n_st = M_HI;
            M_HI:   n_st = M_FIN;
            M_FIN:  n_st = r_axis ? M_IDLE : M_LO;
            default: n_st = M_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_st != M_IDLE);
        o_roll = r_roll;
        o_pitch = r_pitch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= M_IDLE;
            r_axis <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == M_IDLE) begin
                r_axis <= 1'b0;
            end else if (r_st == M_FIN) begin
                r_axis <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            M_LO: r_s <= $signed({21'd0, plo}) + (54'(sel.acc) <<< 16) + 54'sd32768;
            M_HI: r_s <= r_s + (54'(phi) <<< 17);
            M_FIN: begin
                if (r_axis) begin
                    r_pitch <= qs;
                end else begin
                    r_roll <= qs;
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/complementary_filter_attitude_unit.sv */
// Top level of the complementary filter attitude unit: control, state and output register.
// Depends on cfa_pkg, cfa_step_lane, cfa_cordic_lane and cfa_merge.
//
// Usage: IMU transactions arrive on i_in_valid / o_in_stall, results leave on
// o_out_valid / i_out_stall; configuration is written through i_cfg_we, i_cfg_index
// and i_cfg_data while the unit is idle.
// After reset the unit calibrates: the first CALIB_SAMPLES transactions sum the
// gyro bias and give no result. The next transaction primes the held magnetometer
// reading and gives no result. Every later transaction gives one result; o_in_stall
// is high until that result is loaded into the output register.
// The rate is set by the gyro step lanes: a bit-serial multiply by the time delta
// and a radix-4 divide by CALIB_SAMPLES. The three atan2 CORDIC lanes and the step
// lanes run side by side; the merge stage then handles roll and then pitch.
// Results sit in an output register; a new transaction is accepted while a result
// waits there. A running transaction holds until the receiver takes the previous
// result. Reset clears the phase, bias sums, filter state and held magnetometer.
`timescale 1ns / 1ps

module complementary_filter_attitude_unit #(
    parameter int CALIB_SAMPLES = 250
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [15:0]                     i_gyro_x,
    input  logic signed [15:0]                     i_gyro_y,
    input  logic signed [15:0]                     i_gyro_z,
    input  logic signed [15:0]                     i_accel_x,
    input  logic signed [15:0]                     i_accel_y,
    input  logic signed [15:0]                     i_accel_z,
    input  logic [31:0]                            i_sample_time_ms,
    input  logic signed [15:0]                     i_mag_x,
    input  logic signed [15:0]                     i_mag_y,
    input  logic signed [15:0]                     i_mag_z,
    input  logic                                   i_mag_fresh,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [15:0]                     o_roll_angle,
    output logic signed [15:0]                     o_pitch_angle,
    output logic signed [cfa_pkg::ANG_W-1:0]       o_heading_angle,
    output logic [31:0]                            o_out_time_ms,
    input  logic                                   i_cfg_we,
    input  logic [cfa_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [cfa_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import cfa_pkg::*;

    localparam logic [COUNT_W-1:0] CALIB_N = COUNT_W'(CALIB_SAMPLES);

    t_ctl_st r_st, n_st;
    t_phase r_phase;
    logic [COUNT_W-1:0] r_count;
    logic signed [BIAS_W-1:0] r_bias [3];
    logic [31:0] r_last;
    logic signed [15:0] r_roll, r_pitch;
    logic signed [15:0] r_held [3];
    logic signed [15:0] r_off [3];
    logic [15:0] r_scale [3];
    logic [15:0] r_gain;
    logic r_out_valid;

    logic signed [15:0] r_gy, r_gz, r_ax, r_ay, r_az;
    logic [31:0] r_time, r_dt;
    logic signed [DELTA_W-1:0] r_d_roll, r_d_pitch;
    logic signed [33:0] r_cx, r_cy;
    logic signed [15:0] r_o_roll, r_o_pitch;
    logic signed [ANG_W-1:0] r_o_head;
    logic [31:0] r_o_time;

    logic in_acc, lane_start, mrg_start, out_load, lanes_busy;
    logic [COUNT_W-1:0] count_nx;
    logic signed [16:0] mdx, mdy;

    logic sr_busy, sp_busy, cr_busy, cp_busy, ch_busy, mrg_busy;
    logic signed [STEP_W-1:0] step_roll, step_pitch;
    logic signed [ANG_W-1:0] acc_roll, acc_pitch, head;
    logic signed [15:0] mrg_roll, mrg_pitch;
    t_blend_in roll_in, pitch_in;

    assign in_acc = i_in_valid && !o_in_stall;
    assign count_nx = r_count + COUNT_W'(1);
    assign lanes_busy = sr_busy || sp_busy || cr_busy || cp_busy || ch_busy;
    assign mdx = 17'(r_held[0]) - 17'(r_off[0]);
    assign mdy = 17'(r_held[1]) - 17'(r_off[1]);

    always_comb begin
        roll_in.state = r_roll;
        roll_in.step = step_roll;
        roll_in.acc = acc_roll;
        pitch_in.state = r_pitch;
        pitch_in.step = step_pitch;
        pitch_in.acc = acc_pitch;
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (in_acc && r_phase == PH_RUN) n_st = ST_PREP;
            ST_PREP:  n_st = ST_START;
            ST_START: n_st = ST_LANES;
            ST_LANES: if (!lanes_busy) n_st = ST_MERGE;
            ST_MERGE: if (!mrg_busy) n_st = ST_PUSH;
            ST_PUSH:  if (!r_out_valid || !i_out_stall) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_st != ST_IDLE);
        lane_start = (r_st == ST_START);
        mrg_start = (r_st == ST_LANES) && !lanes_busy;
        out_load = (r_st == ST_PUSH) && (!r_out_valid || !i_out_stall);
        o_out_valid = r_out_valid;
        o_roll_angle = r_o_roll;
        o_pitch_angle = r_o_pitch;
        o_heading_angle = r_o_head;
        o_out_time_ms = r_o_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_phase <= PH_CALIB;
            r_count <= '0;
            r_bias <= '{default: '0};
            r_last <= '0;
            r_roll <= '0;
            r_pitch <= '0;
            r_held <= '{default: '0};
            r_off <= '{default: '0};
            r_scale <= '{default: SCALE_RESET};
            r_gain <= GAIN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MAG_OFFSET_X: r_off[0] <= i_cfg_data;
                    REG_MAG_OFFSET_Y: r_off[1] <= i_cfg_data;
                    REG_MAG_OFFSET_Z: r_off[2] <= i_cfg_data;
                    REG_MAG_SCALE_X:  r_scale[0] <= i_cfg_data;
                    REG_MAG_SCALE_Y:  r_scale[1] <= i_cfg_data;
                    REG_MAG_SCALE_Z:  r_scale[2] <= i_cfg_data;
                    REG_BLEND_GAIN:   r_gain <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                case (r_phase)
                    PH_CALIB: begin
                        r_bias[0] <= r_bias[0] + BIAS_W'(i_gyro_x);
                        r_bias[1] <= r_bias[1] + BIAS_W'(i_gyro_y);
                        r_bias[2] <= r_bias[2] + BIAS_W'(i_gyro_z);
                        r_count <= count_nx;
                        if (count_nx >= CALIB_N) begin
                            r_phase <= PH_PRIME;
                            r_last <= i_sample_time_ms;
                        end
                    end
                    PH_PRIME: begin
                        if (i_mag_fresh) begin
                            r_held <= '{i_mag_x, i_mag_y, i_mag_z};
                        end
                        r_phase <= PH_RUN;
                    end
                    PH_RUN: begin
                        if (i_mag_fresh) begin
                            r_held <= '{i_mag_x, i_mag_y, i_mag_z};
                        end
                        r_last <= i_sample_time_ms;
                    end
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_roll <= mrg_roll;
                r_pitch <= mrg_pitch;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_gy <= i_gyro_y;
            r_gz <= i_gyro_z;
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
            r_time <= i_sample_time_ms;
            r_dt <= i_sample_time_ms - r_last;
        end
        if (r_st == ST_PREP) begin
            r_d_roll <= DELTA_W'(r_gz) * DELTA_W'(CALIB_SAMPLES) - DELTA_W'(r_bias[2]);
            r_d_pitch <= DELTA_W'(r_gy) * DELTA_W'(CALIB_SAMPLES) - DELTA_W'(r_bias[1]);
            r_cx <= mdx * $signed({1'b0, r_scale[0]});
            r_cy <= mdy * $signed({1'b0, r_scale[1]});
        end
        if (out_load) begin
            r_o_roll <= mrg_roll;
            r_o_pitch <= mrg_pitch;
            r_o_head <= head;
            r_o_time <= r_time;
        end
    end

    cfa_step_lane #(.CALIB_SAMPLES(CALIB_SAMPLES)) u_step_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(lane_start),
        .i_delta(r_d_roll), .i_dt(r_dt), .o_busy(sr_busy), .o_step(step_roll)
    );

    cfa_step_lane #(.CALIB_SAMPLES(CALIB_SAMPLES)) u_step_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(lane_start),
        .i_delta(r_d_pitch), .i_dt(r_dt), .o_busy(sp_busy), .o_step(step_pitch)
    );

    cfa_cordic_lane u_cor_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(lane_start),
        .i_x(-CW'(r_ax)), .i_y(CW'(r_ay)), .o_busy(cr_busy), .o_angle(acc_roll)
    );

    cfa_cordic_lane u_cor_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(lane_start),
        .i_x(-CW'(r_ax)), .i_y(-CW'(r_az)), .o_busy(cp_busy), .o_angle(acc_pitch)
    );

    cfa_cordic_lane u_cor_head (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(lane_start),
        .i_x(CW'(r_cx)), .i_y(CW'(r_cy)), .o_busy(ch_busy), .o_angle(head)
    );

    cfa_merge u_merge (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mrg_start), .i_gain(r_gain),
        .i_roll_in(roll_in), .i_pitch_in(pitch_in), .o_busy(mrg_busy),
        .o_roll(mrg_roll), .o_pitch(mrg_pitch)
    );

endmodule

/* bench/complementary_filter_attitude_unit_tb.sv */
// Self-checking bench for complementary_filter_attitude_unit: bursty IMU traffic
// through calibration, priming and the running filter against a fixed-point predictor.
// Depends on cfa_pkg and the unit's RTL.
`timescale 1ns / 1ps

module complementary_filter_attitude_unit_tb;
    import cfa_pkg::*;

    localparam int CALIB = 250;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 150;
    localparam longint unsigned GYRO_K = 64'd3937335981;

    typedef struct {
        logic signed [15:0] gyro [3];
        logic signed [15:0] accel [3];
        logic [31:0]        stamp;
        logic signed [15:0] mag [3];
        logic               fresh;
    } t_imu;

    typedef struct {
        logic signed [15:0]      roll;
        logic signed [15:0]      pitch;
        logic signed [ANG_W-1:0] head;
        logic [31:0]             stamp;
    } t_attitude;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [15:0] i_gyro_x = '0, i_gyro_y = '0, i_gyro_z = '0;
    logic signed [15:0] i_accel_x = '0, i_accel_y = '0, i_accel_z = '0;
    logic [31:0] i_sample_time_ms = '0;
    logic signed [15:0] i_mag_x = '0, i_mag_y = '0, i_mag_z = '0;
    logic i_mag_fresh = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [15:0] o_roll_angle, o_pitch_angle;
    logic signed [ANG_W-1:0] o_heading_angle;
    logic [31:0] o_out_time_ms;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    complementary_filter_attitude_unit #(.CALIB_SAMPLES(CALIB)) dut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // predictor state and register copies
    int bias_acc [3];
    int calib_count;
    t_phase phase_now;
    logic [31:0] prev_stamp;
    int roll_now, pitch_now;
    int mag_hold [3];
    int mag_off [3];
    int mag_scl [3];
    int gain_now;

    t_imu pending_q [$];
    t_attitude attitude_q [$];
    t_imu cur_imu;
    int mismatches = 0;
    int results_seen = 0;
    int burst_left = 0;
    int gap_left = 0;
    logic [31:0] ts = 32'd100;

    function automatic longint cordic_atan2(longint y, longint x);
        longint z, nx, ny, dx, dy, r;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                nx = y; ny = -x; z = 90 * 16384;
            end else begin
                nx = -y; ny = x; z = -90 * 16384;
            end
            x = nx; y = ny;
        end
        for (int i = 0; i < 16; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y > 0) begin
                x = x + dy; y = y - dx; z = z + longint'(ATAN_TAB[i]);
            end else begin
                x = x - dy; y = y + dx; z = z - longint'(ATAN_TAB[i]);
            end
        end
        r = (z + 128) >>> 8;
        if (r > 11520) r = 11520;
        if (r < -11520) r = -11520;
        return r;
    endfunction

    function automatic longint gyro_angle_step(longint d, logic [31:0] dt);
        longint unsigned mag, m, hi, lo, p;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        m = mag * {32'b0, dt};
        hi = m >> 32;
        lo = m & 64'hFFFF_FFFF;
        p = (hi * GYRO_K + ((lo * GYRO_K) >> 32)) >> 8;
        p = p / CALIB;
        if (p > 64'h7FFF_FFFF) p = 64'h7FFF_FFFF;
        return (d < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic int blend_angle(int st, longint step, longint acc);
        longint g, s, r;
        g = gain_now;
        s = g * (longint'(st) + step) + (65536 - g) * acc;
        r = (s + 32768) >>> 16;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return int'(r);
    endfunction

    task automatic absorb_sample(input t_imu s);
        logic [31:0] dt;
        longint droll, dpitch, ax, cx, cy;
        t_attitude a;
        if (phase_now == PH_CALIB) begin
            for (int i = 0; i < 3; i++) bias_acc[i] += s.gyro[i];
            calib_count = (calib_count + 1) & 511;
            if (calib_count >= CALIB) begin
                phase_now = PH_PRIME;
                prev_stamp = s.stamp;
            end
            return;
        end
        if (s.fresh) for (int i = 0; i < 3; i++) mag_hold[i] = s.mag[i];
        if (phase_now != PH_RUN) begin
            phase_now = PH_RUN;
            return;
        end
        dt = s.stamp - prev_stamp;
        prev_stamp = s.stamp;
        droll = gyro_angle_step(longint'(s.gyro[2]) * CALIB - bias_acc[2], dt);
        dpitch = gyro_angle_step(longint'(s.gyro[1]) * CALIB - bias_acc[1], dt);
        ax = -longint'(s.accel[0]);
        roll_now = blend_angle(roll_now, droll, cordic_atan2(s.accel[1], ax));
        pitch_now = blend_angle(pitch_now, dpitch, cordic_atan2(-longint'(s.accel[2]), ax));
        cx = (longint'(mag_hold[0]) - mag_off[0]) * mag_scl[0];
        cy = (longint'(mag_hold[1]) - mag_off[1]) * mag_scl[1];
        a.roll = roll_now[15:0];
        a.pitch = pitch_now[15:0];
        a.head = ANG_W'(cordic_atan2(cy, cx));
        a.stamp = s.stamp;
        attitude_q.push_back(a);
    endtask

    function automatic t_imu make_imu(bit noisy);
        t_imu s;
        if (noisy) begin
            for (int i = 0; i < 3; i++) begin
                s.gyro[i] = $urandom; s.accel[i] = $urandom; s.mag[i] = $urandom;
            end
            s.stamp = ($urandom_range(0, 3) == 0) ? $urandom : ts - $urandom_range(0, 50);
        end else begin
            for (int i = 0; i < 3; i++) begin
                s.gyro[i] = $urandom_range(0, 600) - 300;
                s.accel[i] = $urandom_range(0, 8000) - 4000;
                s.mag[i] = $urandom_range(0, 2000) - 1000;
            end
            s.accel[$urandom_range(0, 2)] = ($urandom_range(0, 1) ? 16384 : -16384)
                                            + $urandom_range(0, 4000) - 2000;
            ts = ts + $urandom_range(1, 20);
            s.stamp = ts;
        end
        s.fresh = $urandom_range(0, 1);
        return s;
    endfunction

    function automatic t_imu pick_imu(int gy, int ax, int ay, int az, int mg,
                                      logic [31:0] stamp, bit fresh);
        t_imu s;
        for (int i = 0; i < 3; i++) begin
            s.gyro[i] = gy; s.mag[i] = mg;
        end
        s.accel[0] = ax; s.accel[1] = ay; s.accel[2] = az;
        s.stamp = stamp;
        s.fresh = fresh;
        return s;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) absorb_sample(cur_imu);
            if (i_in_valid && o_in_stall) begin
            end else if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                cur_imu = pending_q.pop_front();
                i_gyro_x <= cur_imu.gyro[0];
                i_gyro_y <= cur_imu.gyro[1];
                i_gyro_z <= cur_imu.gyro[2];
                i_accel_x <= cur_imu.accel[0];
                i_accel_y <= cur_imu.accel[1];
                i_accel_z <= cur_imu.accel[2];
                i_sample_time_ms <= cur_imu.stamp;
                i_mag_x <= cur_imu.mag[0];
                i_mag_y <= cur_imu.mag[1];
                i_mag_z <= cur_imu.mag[2];
                i_mag_fresh <= cur_imu.fresh;
                i_in_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern with one long hold-off
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge i_clk) begin
        if (!hold_done && results_seen >= 60) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (mode_left == 0) begin
            mode_left = 50;
            stall_mode = $urandom_range(0, 3);
        end
        mode_left--;
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_attitude a;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (attitude_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                a = attitude_q.pop_front();
                if (a.roll !== o_roll_angle || a.pitch !== o_pitch_angle
                        || a.head !== o_heading_angle || a.stamp !== o_out_time_ms) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch t=%0d: exp roll %0d pitch %0d head %0d time %0d, got roll %0d pitch %0d head %0d time %0d",
                                 a.stamp, a.roll, a.pitch, a.head, a.stamp,
                                 o_roll_angle, o_pitch_angle, o_heading_angle, o_out_time_ms);
                end
            end
        end
    end

    // watchdog
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we
                || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("complementary_filter_attitude_unit regression: fail");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_q.size() > 0 || i_in_valid || attitude_q.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input int off, input int scl, input int gain, input bit rnd);
        logic [15:0] v;
        for (int i = 0; i < 7; i++) begin
            if (rnd) v = $urandom;
            else if (i < 3) v = off;
            else if (i < 6) v = scl;
            else v = gain;
            @(posedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data <= v;
            case (CFG_IDX_W'(i))
                REG_MAG_OFFSET_X, REG_MAG_OFFSET_Y, REG_MAG_OFFSET_Z:
                    mag_off[i] = int'($signed(v));
                REG_MAG_SCALE_X, REG_MAG_SCALE_Y, REG_MAG_SCALE_Z: mag_scl[i - 3] = v;
                REG_BLEND_GAIN: gain_now = v;
                default: ;
            endcase
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        t_imu s;
        for (int i = 0; i < 3; i++) begin
            bias_acc[i] = 0; mag_hold[i] = 0; mag_off[i] = 0; mag_scl[i] = SCALE_RESET;
        end
        calib_count = 0;
        phase_now = PH_CALIB;
        prev_stamp = '0;
        roll_now = 0;
        pitch_now = 0;
        gain_now = GAIN_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_regs(0, SCALE_RESET, GAIN_RESET, 1'b0);

        // calibration, extremes first, fresh magnetometer ignored here
        pending_q.push_back(pick_imu(32767, 1, 2, 3, 500, ts, 1'b1));
        pending_q.push_back(pick_imu(-32768, 4, 5, 6, -500, ts + 1, 1'b1));
        ts = ts + 2;
        for (int i = 2; i < CALIB; i++) pending_q.push_back(make_imu(1'b0));
        // priming without a fresh reading
        s = make_imu(1'b0);
        s.fresh = 1'b0;
        pending_q.push_back(s);

        // directed corners of the running filter
        pending_q.push_back(pick_imu(0, 0, 0, 0, 0, ts + 10, 1'b0));
        pending_q.push_back(pick_imu(5, 1000, 0, 0, 0, ts + 20, 1'b0));
        pending_q.push_back(pick_imu(32767, -32768, 32767, -32768, 32767, ts + 30, 1'b1));
        pending_q.push_back(pick_imu(-32768, 32767, -32768, 32767, -32768, ts + 40, 1'b1));
        pending_q.push_back(pick_imu(0, -16384, 0, 0, 0, ts + 41, 1'b1));
        pending_q.push_back(pick_imu(100, 0, 16384, 0, 300, ts + 45, 1'b0));
        pending_q.push_back(pick_imu(-100, 0, 0, 16384, 300, ts + 30, 1'b1));
        pending_q.push_back(pick_imu(7, -200, 300, -400, 1000, 32'hFFFF_FFFF, 1'b1));
        pending_q.push_back(pick_imu(-7, 200, -300, 400, -1000, 32'd3, 1'b1));
        pending_q.push_back(pick_imu(1, 0, -5, 0, 0, 32'd3, 1'b0));
        ts = 32'd10;
        wait_drained();

        for (int ph = 1; ph <= 5; ph++) begin
            case (ph)
                1: write_regs(32767, 65535, 65535, 1'b0);
                2: write_regs(-32768, 0, 0, 1'b0);
                default: write_regs(0, 0, 0, 1'b1);
            endcase
            for (int i = 0; i < 140; i++) pending_q.push_back(make_imu($urandom_range(0, 6) == 0));
            wait_drained();
        end

        if (mismatches == 0 && attitude_q.size() == 0) begin
            $display("complementary_filter_attitude_unit regression: pass");
        end else begin
            $display("complementary_filter_attitude_unit regression: fail");
        end
        $finish;
    end

endmodule
